[rtl/sccb_pkg.sv]
package sccb_pkg;

    localparam int STEP_W  = 7;
    localparam int TICK_W  = 20;
    localparam int PHASE_W = 16;
    localparam int FRAME_W = 32;
    localparam int CFG_W   = 20;
    localparam int CFG_IDX_W = 2;

    // step map
    localparam logic [STEP_W-1:0] STEP_START_LOW = 7'd2;
    localparam logic [STEP_W-1:0] STEP_DATA_FIRST = 7'd3;
    localparam logic [STEP_W-1:0] STEP_DATA_LAST  = 7'd110;
    localparam logic [STEP_W-1:0] STEP_STOP_FIRST = 7'd111;
    localparam logic [STEP_W-1:0] STEP_STOP_SCL   = 7'd112;
    localparam logic [STEP_W-1:0] STEP_STOP_SDA   = 7'd113;
    localparam logic [STEP_W-1:0] STEP_GAP        = 7'd114;

    // bit slot counters inside the data region
    localparam logic [1:0] PHASE_LAST = 2'd2;
    localparam logic [1:0] PHASE_HIGH = 2'd1;
    localparam logic [3:0] SLOT_LAST  = 4'd8;
    localparam logic [3:0] SLOT_ACK   = 4'd8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_TICKS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS      = 2'd2;

    localparam logic [7:0]         DEVICE_ADDRESS_RST = 8'h78;
    localparam logic [PHASE_W-1:0] PHASE_TICKS_RST    = 16'd10;
    localparam logic [TICK_W-1:0]  GAP_TICKS_RST      = 20'd2000;

    // request codes
    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic [1:0]        phase;
        logic [3:0]        slot;
        logic [1:0]        byte_sel;
    } sccb_pos_t;

endpackage

[rtl/sccb_levels.sv]
module sccb_levels
    import sccb_pkg::*;
(
    input  sccb_pos_t            pos,
    input  logic [FRAME_W-1:0]   frame,
    output logic                 scl,
    output logic                 sda
);

    logic [4:0] bit_idx;

    // byte 0 sits in bits 31..24, MSB first
    assign bit_idx = ~{pos.byte_sel, pos.slot[2:0]};

    always_comb
    begin
        if (pos.step < STEP_DATA_FIRST)
        begin
            scl = (pos.step < STEP_START_LOW);
            sda = (pos.step == '0);
        end
        else if (pos.step <= STEP_DATA_LAST)
        begin
            scl = (pos.phase == PHASE_HIGH);
            sda = (pos.slot == SLOT_ACK) ? 1'b0 : frame[bit_idx];
        end
        else if (pos.step < STEP_GAP)
        begin
            scl = (pos.step >= STEP_STOP_SCL);
            sda = (pos.step == STEP_STOP_SDA);
        end
        else
        begin
            scl = 1'b1;
            sda = 1'b1;
        end
    end

endmodule

[rtl/sccb_seq.sv]
module sccb_seq
    import sccb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 func,
    input  logic [7:0]           addr_high,
    input  logic [7:0]           addr_low,
    input  logic [7:0]           write_data,
    input  logic [7:0]           device_address,
    input  logic [PHASE_W-1:0]   phase_ticks,
    input  logic [TICK_W-1:0]    gap_ticks,
    output sccb_pos_t            pos_next,
    output logic [FRAME_W-1:0]   frame_next,
    output logic                 active_next,
    output logic                 done,
    output logic                 rejected
);

    sccb_pos_t          pos_reg;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [FRAME_W-1:0] frame_reg;
    logic               active_reg;

    logic [TICK_W-1:0]  tick_inc;
    logic [TICK_W-1:0]  limit;
    logic [STEP_W-1:0]  step_inc;

    assign tick_inc = tick_reg + 1'b1;
    assign limit    = (phase_ticks == '0) ? TICK_W'(1) : {{(TICK_W-PHASE_W){1'b0}}, phase_ticks};
    assign step_inc = pos_reg.step + 1'b1;

    always_comb
    begin
        pos_next    = pos_reg;
        tick_next   = tick_reg;
        frame_next  = frame_reg;
        active_next = active_reg;
        done        = 1'b0;
        rejected    = 1'b0;
        if (accept)
        begin
            if (func == FUNC_REQUEST)
            begin
                if (active_reg)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    frame_next    = {device_address, addr_high, addr_low, write_data};
                    active_next   = 1'b1;
                    pos_next.step = '0;
                    tick_next     = '0;
                end
            end
            else if (active_reg)
            begin
                tick_next = tick_inc;
                if (pos_reg.step < STEP_GAP)
                begin
                    if (tick_inc >= limit)
                    begin
                        tick_next     = '0;
                        pos_next.step = step_inc;
                        if (step_inc == STEP_DATA_FIRST)
                        begin
                            pos_next.phase    = '0;
                            pos_next.slot     = '0;
                            pos_next.byte_sel = '0;
                        end
                        else if (pos_reg.phase != PHASE_LAST)
                        begin
                            pos_next.phase = pos_reg.phase + 1'b1;
                        end
                        else
                        begin
                            pos_next.phase = '0;
                            if (pos_reg.slot != SLOT_LAST)
                            begin
                                pos_next.slot = pos_reg.slot + 1'b1;
                            end
                            else
                            begin
                                pos_next.slot     = '0;
                                pos_next.byte_sel = pos_reg.byte_sel + 1'b1;
                            end
                        end
                        if (step_inc == STEP_GAP && gap_ticks == '0)
                        begin
                            active_next = 1'b0;
                            done        = 1'b1;
                        end
                    end
                end
                else if (tick_inc >= gap_ticks)
                begin
                    active_next = 1'b0;
                    done        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            tick_reg   <= '0;
            frame_reg  <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            tick_reg   <= tick_next;
            frame_reg  <= frame_next;
            active_reg <= active_next;
        end
    end

endmodule

[rtl/sccb_register_write_master.sv]
// SCCB register write master. Each request is either one time tick (func 0)
// or a write request (func 1) carrying a 16-bit register address and a data
// byte; every request returns exactly one result with the SCL/SDA levels, busy,
// done and rejected flags as they stand after that request. A write drives
// start, four bytes MSB first (device address, address high, address low,
// data) each followed by an acknowledge clock holding SDA low, then stop, then an idle gap;
// each pin step holds for phase_ticks ticks (0 acts as 1), the gap for
// gap_ticks. A write request while busy is rejected and changes nothing.
// Rate: one request per clock while the consumer keeps up, results registered;
// the result register decouples the two sides so a new request is taken while
// the last result waits, as long as the consumer takes that result in the same
// cycle. Configuration is a plain write port and takes effect immediately.
module sccb_register_write_master
    import sccb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wr_data,
    // request channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  func,
    input  logic [7:0]            addr_high,
    input  logic [7:0]            addr_low,
    input  logic [7:0]            write_data,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  scl_out,
    output logic                  sda_out,
    output logic                  busy_flag,
    output logic                  done_pulse,
    output logic                  rejected_flag
);

    // configuration registers
    logic [7:0]         device_address_reg;
    logic [PHASE_W-1:0] phase_ticks_reg;
    logic [TICK_W-1:0]  gap_ticks_reg;

    // result register
    logic out_valid_reg;
    logic scl_reg, sda_reg, busy_reg, done_reg, rejected_reg;

    logic               accept;
    sccb_pos_t          pos_next;
    logic [FRAME_W-1:0] frame_next;
    logic               active_next;
    logic               done;
    logic               rejected;
    logic               scl_next, sda_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= DEVICE_ADDRESS_RST;
            phase_ticks_reg    <= PHASE_TICKS_RST;
            gap_ticks_reg      <= GAP_TICKS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DEVICE_ADDRESS: device_address_reg <= cfg_wr_data[7:0];
                REG_PHASE_TICKS:    phase_ticks_reg    <= cfg_wr_data[PHASE_W-1:0];
                REG_GAP_TICKS:      gap_ticks_reg      <= cfg_wr_data[TICK_W-1:0];
                default:            ;  // unmapped index, dropped
            endcase
        end
    end

    // sequencer: tick counter, step position, latched frame
    sccb_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .func           (func),
        .addr_high      (addr_high),
        .addr_low       (addr_low),
        .write_data     (write_data),
        .device_address (device_address_reg),
        .phase_ticks    (phase_ticks_reg),
        .gap_ticks      (gap_ticks_reg),
        .pos_next       (pos_next),
        .frame_next     (frame_next),
        .active_next    (active_next),
        .done           (done),
        .rejected       (rejected)
    );

    // pin levels follow directly from the step position and the latched frame
    sccb_levels u_levels (
        .pos   (pos_next),
        .frame (frame_next),
        .scl   (scl_next),
        .sda   (sda_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            busy_reg     <= active_next;
            done_reg     <= done;
            rejected_reg <= rejected;
        end
    end

    assign out_valid     = out_valid_reg;
    assign scl_out       = scl_reg;
    assign sda_out       = sda_reg;
    assign busy_flag     = busy_reg;
    assign done_pulse    = done_reg;
    assign rejected_flag = rejected_reg;

endmodule

[tb/testbench.sv]
module testbench;
    import sccb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Each bit slot is three steps (SDA set, SCL high, SCL low); nine slots per octet,
    // eight of them carry data, the ninth is the acknowledge clock with SDA low.
    localparam int STEPS_PER_SLOT  = 3;
    localparam int STEPS_PER_OCTET = 27;
    localparam int DATA_STEPS      = 24;
    localparam int SLOT_HIGH       = 1;

    // Index past the register list; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    localparam int MAX_WAIT     = 18;    // per-request idle draw on either side
    localparam int HOLD_CYCLES  = 250;   // long output hold-off for the fill test
    localparam int SETTLE       = 4;     // cycles after last result before a write
    localparam int IDLE_LIMIT   = 2000;  // watchdog: cycles with no handshake at all
    localparam int RANDOM_ROUNDS = 5;

    typedef struct packed {
        logic scl;
        logic sda;
        logic busy;
        logic done;
        logic rejected;
    } bus_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wr_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 func;
    logic [7:0]           addr_high;
    logic [7:0]           addr_low;
    logic [7:0]           write_data;
    logic                 out_valid;
    logic                 out_ready;
    logic                 scl_out;
    logic                 sda_out;
    logic                 busy_flag;
    logic                 done_pulse;
    logic                 rejected_flag;

    // Shadow of the bus sequencer, advanced once per accepted request.
    logic [7:0]         dev_addr_cfg;
    logic [PHASE_W-1:0] phase_cfg;
    logic [TICK_W-1:0]  gap_cfg;
    logic               scl_lvl;
    logic               sda_lvl;
    logic               bus_running;
    logic [STEP_W-1:0]  bus_step;
    logic [TICK_W-1:0]  hold_cnt;
    logic [FRAME_W-1:0] frame_bytes;

    bus_result_t expected_levels[$];

    // Traffic shaping knobs, flipped by the tests.
    logic tx_quiet;
    logic rx_quiet;
    logic hold_out;

    int error_count;
    int results_checked;
    int requests_sent;
    int writes_started;
    int writes_done;
    int writes_rejected;
    int idle_cycles;

    sccb_register_write_master dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .addr_high    (addr_high),
        .addr_low     (addr_low),
        .write_data   (write_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .scl_out      (scl_out),
        .sda_out      (sda_out),
        .busy_flag    (busy_flag),
        .done_pulse   (done_pulse),
        .rejected_flag(rejected_flag)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Bus sequencer prediction
    // ------------------------------------------------------------------

    function automatic void reset_bus_shadow();
        dev_addr_cfg = DEVICE_ADDRESS_RST;
        phase_cfg    = PHASE_TICKS_RST;
        gap_cfg      = GAP_TICKS_RST;
        scl_lvl      = 1'b1;
        sda_lvl      = 1'b1;
        bus_running  = 1'b0;
        bus_step     = '0;
        hold_cnt     = '0;
        frame_bytes  = '0;
    endfunction

    // Pin levels for a given step of the frame.
    function automatic void load_step_levels(input logic [STEP_W-1:0] s);
        int unsigned offset;
        int unsigned octet_no;
        int unsigned pos;
        logic [7:0]  octet;
        if (s < STEP_DATA_FIRST)
        begin
            // start: both high, then SDA falls, then SCL falls
            scl_lvl = (s < STEP_START_LOW);
            sda_lvl = (s == '0);
        end
        else if (s < STEP_STOP_FIRST)
        begin
            offset   = s - STEP_DATA_FIRST;
            octet_no = offset / STEPS_PER_OCTET;
            pos      = offset % STEPS_PER_OCTET;
            octet    = frame_bytes[FRAME_W - 1 - 8 * octet_no -: 8];
            // MSB first; ack slot keeps SDA low
            sda_lvl  = (pos < DATA_STEPS) ? octet[7 - pos / STEPS_PER_SLOT] : 1'b0;
            scl_lvl  = ((pos % STEPS_PER_SLOT) == SLOT_HIGH);
        end
        else if (s < STEP_GAP)
        begin
            // stop: SDA low, SCL rises, then SDA rises
            scl_lvl = (s >= STEP_STOP_SCL);
            sda_lvl = (s == STEP_STOP_SDA);
        end
        else
        begin
            scl_lvl = 1'b1;
            sda_lvl = 1'b1;
        end
    endfunction

    function automatic bus_result_t predict_bus_levels(input logic kind,
                                                       input logic [7:0] hi,
                                                       input logic [7:0] lo,
                                                       input logic [7:0] val);
        bus_result_t r;
        logic [PHASE_W-1:0] step_len;
        r.done     = 1'b0;
        r.rejected = 1'b0;
        if (kind == FUNC_REQUEST)
        begin
            if (bus_running)
                r.rejected = 1'b1;   // busy: nothing else moves
            else
            begin
                frame_bytes = {dev_addr_cfg, hi, lo, val};
                bus_running = 1'b1;
                bus_step    = '0;
                hold_cnt    = '0;
                load_step_levels('0);
            end
        end
        else if (bus_running)
        begin
            hold_cnt = hold_cnt + 1'b1;
            if (bus_step < STEP_GAP)
            begin
                step_len = (phase_cfg == '0) ? PHASE_W'(1) : phase_cfg;
                if (hold_cnt >= TICK_W'(step_len))
                begin
                    bus_step = bus_step + 1'b1;
                    hold_cnt = '0;
                    load_step_levels(bus_step);
                    // no gap: frame ends on the tick that finishes the stop
                    if (bus_step == STEP_GAP && gap_cfg == '0)
                    begin
                        bus_running = 1'b0;
                        r.done      = 1'b1;
                    end
                end
            end
            else if (hold_cnt >= gap_cfg)
            begin
                bus_running = 1'b0;
                r.done      = 1'b1;
            end
        end
        r.scl  = scl_lvl;
        r.sda  = sda_lvl;
        r.busy = bus_running;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offers one request, holds it until taken, then records what it must return.
    // Returns at the accepting rising edge with valid still high.
    task automatic send_request(input logic kind, input logic [7:0] hi,
                                input logic [7:0] lo, input logic [7:0] val);
        int gap;
        bus_result_t want;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        func       <= kind;
        addr_high  <= hi;
        addr_low   <= lo;
        write_data <= val;
        do @(posedge clk); while (!in_ready);
        want = predict_bus_levels(kind, hi, lo, val);
        expected_levels.push_back(want);
        requests_sent++;
        if (kind == FUNC_REQUEST && !want.rejected)
            writes_started++;
        if (want.rejected)
            writes_rejected++;
        if (want.done)
            writes_done++;
    endtask

    task automatic send_tick();
        send_request(FUNC_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
    endtask

    task automatic run_ticks(input int n);
        repeat (n) send_tick();
    endtask

    task automatic run_until_idle();
        while (bus_running)
            send_tick();
    endtask

    task automatic run_to_gap();
        while (bus_running && bus_step < STEP_GAP)
            send_tick();
    endtask

    // Stop offering and wait for every outstanding result; ends on a rising edge.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_levels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Register write; callers drain first so nothing is in flight.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        case (idx)
            REG_DEVICE_ADDRESS: dev_addr_cfg = val[7:0];
            REG_PHASE_TICKS:    phase_cfg    = val[PHASE_W-1:0];
            REG_GAP_TICKS:      gap_cfg      = val[TICK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_bus(input logic [7:0] dev, input logic [PHASE_W-1:0] phase,
                               input logic [TICK_W-1:0] gap);
        drain_results();
        write_reg(REG_DEVICE_ADDRESS, CFG_W'(dev));
        write_reg(REG_PHASE_TICKS, CFG_W'(phase));
        write_reg(REG_GAP_TICKS, CFG_W'(gap));
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("[%0t] result %0d: %s: got %0d, expected %0d",
                 $realtime, results_checked, what, got, want);
    endtask

    task automatic check_bus_result();
        bus_result_t want;
        if (expected_levels.size() == 0)
            report_mismatch("result with no request pending", 1, 0);
        else
        begin
            want = expected_levels.pop_front();
            if (scl_out !== want.scl)
                report_mismatch("scl_out", scl_out, want.scl);
            if (sda_out !== want.sda)
                report_mismatch("sda_out", sda_out, want.sda);
            if (busy_flag !== want.busy)
                report_mismatch("busy_flag", busy_flag, want.busy);
            if (done_pulse !== want.done)
                report_mismatch("done_pulse", done_pulse, want.done);
            if (rejected_flag !== want.rejected)
                report_mismatch("rejected_flag", rejected_flag, want.rejected);
        end
        results_checked++;
    endtask

    // Receiver: random stall before each result, or one long hold-off on request.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = rx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (hold_out)
            begin
                stall    = HOLD_CYCLES;
                hold_out = 1'b0;
            end
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            check_bus_result();
        end
    end

    // Watchdog: any stretch without a handshake on either side beyond the limit.
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[%0t] no handshake for %0d cycles", $realtime, IDLE_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Ticks with nothing running leave the lines high and the block idle.
    task automatic test_idle_ticks();
        run_ticks(3);
    endtask

    // Frame under reset settings, then shortened and cut by register writes
    // while it runs; a request on top of it is rejected.
    task automatic test_reset_settings();
        send_request(FUNC_REQUEST, 8'hFF, 8'h00, 8'hA5);
        run_ticks(25);                    // reset step length carries it to step 2
        drain_results();
        write_reg(REG_PHASE_TICKS, '0);   // zero acts as one, takes effect now
        run_ticks(3);
        send_request(FUNC_REQUEST, 8'h5A, 8'hC3, 8'h0F);
        run_to_gap();
        run_ticks(30);                    // still inside the reset gap
        drain_results();
        write_reg(REG_GAP_TICKS, '0);
        run_ticks(1);                     // gap already exceeded: done now
        run_ticks(2);
    endtask

    // No trailing gap: done lands with the stop; back-to-back frames.
    task automatic test_zero_gap();
        program_bus(8'hFF, PHASE_W'(1), '0);
        send_request(FUNC_REQUEST, 8'h00, 8'hFF, 8'h00);
        run_until_idle();
        send_request(FUNC_REQUEST, 8'hFF, 8'h00, 8'hFF);
        run_until_idle();
    endtask

    // Largest step and gap lengths, cut short by writes mid-frame;
    // a write past the register list must change nothing.
    task automatic test_extreme_settings();
        program_bus(8'h00, '1, '1);
        drain_results();
        write_reg(REG_UNMAPPED, '1);
        send_request(FUNC_REQUEST, 8'h81, 8'h7E, 8'h3C);
        run_ticks(20);
        drain_results();
        write_reg(REG_PHASE_TICKS, CFG_W'(1));
        run_to_gap();
        run_ticks(20);
        drain_results();
        write_reg(REG_GAP_TICKS, CFG_W'(5));
        run_until_idle();
    endtask

    // Output held off for a long stretch while requests keep coming back to
    // back, so the block fills and stops taking requests; then a full pause.
    task automatic test_output_hold();
        program_bus(8'($urandom_range(0, 255)), PHASE_W'(2), TICK_W'(3));
        tx_quiet = 1'b1;
        hold_out = 1'b1;
        send_request(FUNC_REQUEST, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        run_ticks(60);
        drain_results();
        tx_quiet = 1'b0;
        run_until_idle();
    endtask

    // Mostly ticks while a frame runs, mostly fresh requests when idle,
    // some requests landing on a busy bus.
    task automatic random_items(input int target);
        int   counted;
        logic kind;
        counted = 0;
        while (counted < target)
        begin
            if (bus_running)
                kind = ($urandom_range(0, 40) == 0) ? FUNC_REQUEST : FUNC_TICK;
            else
                kind = ($urandom_range(0, 3) != 0) ? FUNC_REQUEST : FUNC_TICK;
            if ((kind == FUNC_REQUEST) != bus_running)
                counted++;
            send_request(kind, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
        end
    endtask

    function automatic logic [PHASE_W-1:0] pick_phase();
        case ($urandom_range(0, 4))
            0:       return '0;
            1, 2:    return PHASE_W'(1);
            default: return PHASE_W'(2);
        endcase
    endfunction

    task automatic test_random_traffic();
        logic [TICK_W-1:0] gap_pick;
        for (int round = 0; round < RANDOM_ROUNDS; round++)
        begin
            gap_pick = ($urandom_range(0, 2) == 0) ? '0 : TICK_W'($urandom_range(1, 12));
            program_bus(8'($urandom_range(0, 255)), pick_phase(), gap_pick);
            tx_quiet = (round % 3 == 2);
            rx_quiet = (round % 4 == 1);
            random_items(60);
            // step length changed wherever the frame happens to be
            drain_results();
            write_reg(REG_PHASE_TICKS, CFG_W'(pick_phase()));
            random_items(60);
            tx_quiet = 1'b0;
            rx_quiet = 1'b0;
        end
        run_until_idle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        func        = FUNC_TICK;
        addr_high   = '0;
        addr_low    = '0;
        write_data  = '0;
        tx_quiet    = 1'b0;
        rx_quiet    = 1'b0;
        hold_out    = 1'b0;
        error_count     = 0;
        results_checked = 0;
        requests_sent   = 0;
        writes_started  = 0;
        writes_done     = 0;
        writes_rejected = 0;
        reset_bus_shadow();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_ticks();
        test_reset_settings();
        test_zero_gap();
        test_extreme_settings();
        test_output_hold();
        test_random_traffic();
        drain_results();

        $display("covered: %0d requests, %0d results checked", requests_sent,
                 results_checked);
        $display("covered: %0d writes started, %0d completed, %0d rejected while busy",
                 writes_started, writes_done, writes_rejected);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

[filelist.f]
rtl/sccb_pkg.sv
rtl/sccb_levels.sv
rtl/sccb_seq.sv
rtl/sccb_register_write_master.sv
tb/testbench.sv
